@@ hw/rtl/cpde_pkg.sv @@
// Shared types and constants of the control point delta encoder.
package cpde_pkg;

   typedef enum logic [2:0] {
      OP_HEADER = 3'd0,
      OP_LAYER  = 3'd1,
      OP_BRANCH = 3'd2,
      OP_POINT  = 3'd3,
      OP_END    = 3'd4
   } op_type;

   localparam logic [1:0] CSR_IMAGE_WIDTH    = 2'd0;
   localparam logic [1:0] CSR_IMAGE_HEIGHT   = 2'd1;
   localparam logic [1:0] CSR_COLOR_SPACE    = 2'd2;
   localparam logic [1:0] CSR_CHANNEL_FACTOR = 2'd3;

   localparam logic [7:0] END_MARK = 8'hFF;
   localparam logic signed [16:0] DELTA_LIMIT = 17'sd127;

   localparam int CMD_BYTES   = 8;
   localparam int BYTE_IDX_W  = $clog2(CMD_BYTES);
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // One classified command: its bytes in send order (entry 0 first) and
   // the index of its final byte.
   typedef struct packed {
      logic [BYTE_IDX_W-1:0]           last_idx;
      logic [CMD_BYTES-1:0][7:0]       bytes;
   } cmd_type;

   function automatic logic is_wide(logic signed [16:0] d);
      return (d > DELTA_LIMIT) || (d < -DELTA_LIMIT);
   endfunction

endpackage

@@ hw/rtl/control_point_delta_encoder.sv @@
// Top level of the control point delta encoder.
// Turns header, layer, branch, point and end commands into the skeleton
// control point byte stream on the rsp_ channel, one byte per cycle unless
// rsp_tready holds it back. Bytes per command: header 6, layer start 2,
// branch 3 (an empty branch 1), point 3 (8 when escaped), end 1; unused
// operation codes are taken and give nothing. The byte serializer sets the
// rate; a four-entry command queue lets the front end take new commands
// while earlier ones are still going out, and a command is taken in any cycle
// the queue has room. rsp_tlast marks the final byte of each command. The csr_
// registers must be written only while the block is idle; nothing enforces it.
module control_point_delta_encoder (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_we,
   input  logic [1:0]   csr_index,
   input  logic [15:0]  csr_wdata,
   input  logic         req_tvalid,
   output logic         req_tready,
   // point_x, point_y, point_radius, layer_level, invert_flag, point_count,
   // curve_degree, sample_count
   input  logic [87:0]  req_tdata,
   // operation
   input  logic [2:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // out_byte
   output logic [7:0]   rsp_tdata,
   // last_byte
   output logic         rsp_tlast
);

   cpde_pkg::cmd_type push_cmd, head;
   logic push_valid, full, empty, pop;

   cpde_front u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .queue_full (full),
      .push_valid (push_valid),
      .push_cmd   (push_cmd)
   );

   cpde_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .full       (full),
      .pop        (pop),
      .empty      (empty),
      .head       (head)
   );

   cpde_back u_back (
      .clock      (clock),
      .reset      (reset),
      .empty      (empty),
      .head       (head),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

@@ hw/rtl/cpde_front.sv @@
// Front end: configuration registers, command classification and delta forming.
module cpde_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [1:0]            csr_index,
   input  logic [15:0]           csr_wdata,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [87:0]           req_tdata,
   input  logic [2:0]            req_tuser,
   input  logic                  queue_full,
   output logic                  push_valid,
   output cpde_pkg::cmd_type     push_cmd
);

   logic [15:0] image_width_ff, image_height_ff;
   logic [7:0]  color_space_ff, channel_factor_ff;
   logic [15:0] prev_x_ff, prev_y_ff, prev_r_ff;
   logic [15:0] prev_x_in, prev_y_in, prev_r_in;

   logic [15:0] pt_x, pt_y, pt_r, sample_count;
   logic [7:0]  layer_level, invert_flag;
   logic [3:0]  point_count, curve_degree;
   cpde_pkg::op_type op;
   logic signed [16:0] dx, dx_raw, dy, dr;
   logic        accept, has_bytes;

   assign pt_x         = req_tdata[15:0];
   assign pt_y         = req_tdata[31:16];
   assign pt_r         = req_tdata[47:32];
   assign layer_level  = req_tdata[55:48];
   assign invert_flag  = req_tdata[63:56];
   assign point_count  = req_tdata[67:64];
   assign curve_degree = req_tdata[71:68];
   assign sample_count = req_tdata[87:72];
   assign op           = cpde_pkg::op_type'(req_tuser);

   assign req_tready = !queue_full;
   assign accept     = req_tvalid && req_tready;
   assign push_valid = accept && has_bytes;

   assign dx_raw = $signed({1'b0, pt_x}) - $signed({1'b0, prev_x_ff});
   assign dy     = $signed({1'b0, pt_y}) - $signed({1'b0, prev_y_ff});
   assign dr     = $signed({1'b0, pt_r}) - $signed({1'b0, prev_r_ff});
   // no motion in the plane: send a unit x step, keep the true x
   assign dx     = (dx_raw == 17'sd0 && dy == 17'sd0) ? 17'sd1 : dx_raw;

   always_comb begin
      push_cmd  = '0;
      has_bytes = 1'b1;
      prev_x_in = prev_x_ff;
      prev_y_in = prev_y_ff;
      prev_r_in = prev_r_ff;
      unique case (op)
         cpde_pkg::OP_HEADER: begin
            push_cmd.bytes[0] = image_width_ff[15:8];
            push_cmd.bytes[1] = image_width_ff[7:0];
            push_cmd.bytes[2] = image_height_ff[15:8];
            push_cmd.bytes[3] = image_height_ff[7:0];
            push_cmd.bytes[4] = color_space_ff;
            push_cmd.bytes[5] = channel_factor_ff;
            push_cmd.last_idx = 3'd5;
         end
         cpde_pkg::OP_LAYER: begin
            push_cmd.bytes[0] = layer_level;
            push_cmd.bytes[1] = invert_flag;
            push_cmd.last_idx = 3'd1;
         end
         cpde_pkg::OP_BRANCH: begin
            if (point_count == 4'd0) begin
               push_cmd.last_idx = 3'd0;
            end else begin
               push_cmd.bytes[0] = {point_count, curve_degree};
               push_cmd.bytes[1] = sample_count[15:8];
               push_cmd.bytes[2] = sample_count[7:0];
               push_cmd.last_idx = 3'd2;
            end
         end
         cpde_pkg::OP_POINT: begin
            if (cpde_pkg::is_wide(dx) || cpde_pkg::is_wide(dy) || cpde_pkg::is_wide(dr)) begin
               // escape word, then three 16-bit deltas
               push_cmd.bytes[2] = dx[15:8];
               push_cmd.bytes[3] = dx[7:0];
               push_cmd.bytes[4] = dy[15:8];
               push_cmd.bytes[5] = dy[7:0];
               push_cmd.bytes[6] = dr[15:8];
               push_cmd.bytes[7] = dr[7:0];
               push_cmd.last_idx = 3'd7;
            end else begin
               push_cmd.bytes[0] = dx[7:0];
               push_cmd.bytes[1] = dy[7:0];
               push_cmd.bytes[2] = dr[7:0];
               push_cmd.last_idx = 3'd2;
            end
            prev_x_in = pt_x;
            prev_y_in = pt_y;
            prev_r_in = pt_r;
         end
         cpde_pkg::OP_END: begin
            push_cmd.bytes[0] = cpde_pkg::END_MARK;
            push_cmd.last_idx = 3'd0;
         end
         default: begin
            has_bytes = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff    <= '0;
         image_height_ff   <= '0;
         color_space_ff    <= '0;
         channel_factor_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            cpde_pkg::CSR_IMAGE_WIDTH:    image_width_ff    <= csr_wdata;
            cpde_pkg::CSR_IMAGE_HEIGHT:   image_height_ff   <= csr_wdata;
            cpde_pkg::CSR_COLOR_SPACE:    color_space_ff    <= csr_wdata[7:0];
            cpde_pkg::CSR_CHANNEL_FACTOR: channel_factor_ff <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_x_ff <= '0;
         prev_y_ff <= '0;
         prev_r_ff <= '0;
      end else if (accept) begin
         prev_x_ff <= prev_x_in;
         prev_y_ff <= prev_y_in;
         prev_r_ff <= prev_r_in;
      end
   end

endmodule

@@ hw/rtl/cpde_queue.sv @@
// Command queue between the classifying front end and the byte serializer.
module cpde_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push_valid,
   input  cpde_pkg::cmd_type     push_cmd,
   output logic                  full,
   input  logic                  pop,
   output logic                  empty,
   output cpde_pkg::cmd_type     head
);

   cpde_pkg::cmd_type mem_ff [cpde_pkg::QUEUE_DEPTH];
   logic [cpde_pkg::QUEUE_PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [cpde_pkg::QUEUE_CNT_W-1:0] count_ff, count_in;
   logic do_push, do_pop;

   assign full    = (count_ff == cpde_pkg::QUEUE_CNT_W'(cpde_pkg::QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign head    = mem_ff[rd_ptr_ff];
   assign do_push = push_valid && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (do_pop)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
         count_ff <= count_in;
      end
   end

`ifndef SYNTH
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      !(push_valid && full)) else $error("push into a full command queue");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= cpde_pkg::QUEUE_CNT_W'(cpde_pkg::QUEUE_DEPTH))
      else $error("command queue count out of range");
   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      (wr_ptr_ff - rd_ptr_ff) == count_ff[cpde_pkg::QUEUE_PTR_W-1:0])
      else $error("queue pointers disagree with count");
   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      (do_push && !do_pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("push without pop did not grow the queue");
`endif

endmodule

@@ hw/rtl/cpde_back.sv @@
// Back end: serializes each queued command onto the byte stream.
module cpde_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  empty,
   input  cpde_pkg::cmd_type     head,
   output logic                  pop,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [7:0]            rsp_tdata,
   output logic                  rsp_tlast
);

   logic [cpde_pkg::BYTE_IDX_W-1:0] idx_ff, idx_in;
   logic xfer;

   assign rsp_tvalid = !empty;
   assign rsp_tdata  = head.bytes[idx_ff];
   assign rsp_tlast  = (idx_ff == head.last_idx);
   assign xfer       = rsp_tvalid && rsp_tready;
   assign pop        = xfer && rsp_tlast;

   always_comb begin
      idx_in = idx_ff;
      if (pop) begin
         idx_in = '0;
      end else if (xfer) begin
         idx_in = idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else begin
         idx_ff <= idx_in;
      end
   end

`ifndef SYNTH
   a_idx_in_cmd: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (idx_ff <= head.last_idx))
      else $error("byte index ran past the command");
   a_idle_at_start: assert property (@(posedge clock) disable iff (reset)
      empty |-> (idx_ff == '0)) else $error("byte index not cleared while idle");
   a_step: assert property (@(posedge clock) disable iff (reset)
      (xfer && !rsp_tlast) |=> (idx_ff == $past(idx_ff) + 1'b1))
      else $error("byte index did not advance after transfer");
`endif

endmodule
